/* hdl/pdws_pkg.sv */
// Shared types and codes for the palette DAC write sequencer.
package pdws_pkg;

  typedef enum logic [0:0] {
    OP_INDEX = 1'b0,
    OP_DATA  = 1'b1
  } pdws_op_t;

  typedef enum logic [1:0] {
    COMP_RED   = 2'd0,
    COMP_GREEN = 2'd1,
    COMP_BLUE  = 2'd2
  } pdws_comp_t;

  typedef struct packed {
    pdws_op_t    op;
    logic        wr_access;
    logic [7:0]  value;
  } pdws_item_t;

  typedef struct packed {
    logic        stored;
    logic [7:0]  entry_index;
    pdws_comp_t  component;
    logic [7:0]  component_value;
    logic        palette_done;
  } pdws_res_t;

endpackage

/* hdl/palette_dac_write_sequencer.sv */
// Top level of the palette DAC write sequencer with its stream handshake.
// Each bus access is one item and yields one result item. An accepted item passes through
// the input register, then the result register, and one item is accepted
// in every cycle while the result side keeps up; the pointer and counter update in a
// single pass that sets this rate. The palette store holds 3*ENTRIES bytes, is written
// once per data-port write and is never read back, so it needs no clearing after reset.
module palette_dac_write_sequencer import pdws_pkg::*; #(
  parameter int ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // value[7:0]
  input  logic [1:0]  in_tuser,   // op[0], wr_access[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // entry_index[7:0], component_value[15:8]
  output logic [2:0]  out_tuser,  // stored[0], component[2:1]
  output logic        out_tlast   // palette_done
);

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  pdws_item_t s1_item_r;
  pdws_item_t s1_item_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  pdws_res_t  out_res_r;
  pdws_res_t  out_res_nxt;
  pdws_res_t  seq_res;
  logic       out_free;
  logic       advance;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || advance;

  pdws_seq #(
    .ENTRIES (ENTRIES)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (s1_item_r),
    .res   (seq_res)
  );

  always_comb begin
    s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
    s1_item_nxt   = s1_item_r;
    if (in_tready && in_tvalid) begin
      s1_item_nxt.op        = pdws_op_t'(in_tuser[0]);
      s1_item_nxt.wr_access = in_tuser[1];
      s1_item_nxt.value     = in_tdata;
    end
    out_res_nxt = advance ? seq_res : out_res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.component_value, out_res_r.entry_index};
  assign out_tuser  = {out_res_r.component, out_res_r.stored};
  assign out_tlast  = out_res_r.palette_done;

  a_done_is_blue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tlast) |-> (out_tuser[0] && out_tuser[2:1] == COMP_BLUE))
    else $error("palette complete flagged on a result that is not a blue store");

  a_done_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tlast) |-> (out_tdata[7:0] == 8'd0))
    else $error("pointer did not wrap to entry zero at palette end");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while the result register is empty");

  a_no_store_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tuser[0]) |-> (out_tdata[15:8] == 8'd0 && !out_tlast))
    else $error("component value or flag set on an access that stored nothing");

endmodule

/* hdl/pdws_seq.sv */
// Entry pointer, component counter and palette store of the DAC write side.
module pdws_seq import pdws_pkg::*; #(
  parameter int ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  pdws_item_t item,
  output pdws_res_t  res
);

  localparam int PW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AW = $clog2(ENTRIES * 3);

  logic [PW-1:0] ptr_r;
  logic [PW-1:0] ptr_nxt;
  pdws_comp_t    comp_r;
  pdws_comp_t    comp_nxt;
  pdws_comp_t    comp_cur;
  logic [7:0]    cval;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [PW-1:0] mod_tbl [256];
  logic [7:0]    pal_mem [ENTRIES*3];

  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tbl[g] = PW'(g % ENTRIES);
  end

  assign cval     = {item.value[5:0], 2'b00};
  assign mem_addr = AW'(ptr_r) * AW'(3) + AW'(comp_cur);

  always_comb begin
    case (comp_r)
      COMP_RED:   comp_cur = COMP_RED;
      COMP_GREEN: comp_cur = COMP_GREEN;
      default:    comp_cur = COMP_BLUE;
    endcase
  end

  always_comb begin
    ptr_nxt             = ptr_r;
    comp_nxt            = comp_r;
    mem_we              = 1'b0;
    res.stored          = 1'b0;
    res.component       = COMP_RED;
    res.component_value = 8'd0;
    res.palette_done    = 1'b0;
    if (item.wr_access) begin
      case (item.op)
        OP_INDEX: begin
          ptr_nxt  = mod_tbl[item.value];
          comp_nxt = COMP_RED;
        end
        OP_DATA: begin
          mem_we              = 1'b1;
          res.stored          = 1'b1;
          res.component       = comp_cur;
          res.component_value = cval;
          case (comp_cur)
            COMP_RED:   comp_nxt = COMP_GREEN;
            COMP_GREEN: comp_nxt = COMP_BLUE;
            default: begin
              comp_nxt = COMP_RED;
              if (ptr_r == PW'(ENTRIES - 1)) begin
                ptr_nxt          = '0;
                res.palette_done = 1'b1;
              end else begin
                ptr_nxt = ptr_r + PW'(1);
              end
            end
          endcase
        end
        default: begin
          ptr_nxt = ptr_r;
        end
      endcase
    end
    res.entry_index = 8'(ptr_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      comp_r <= COMP_RED;
    end else if (step) begin
      ptr_r  <= ptr_nxt;
      comp_r <= comp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && mem_we) begin
      pal_mem[mem_addr] <= cval;
    end
  end

endmodule
